// ===== rtl/core/cdts_pkg.sv =====
// shared widths, codes and table entry type of the counter decay task scheduler
`timescale 1ns / 1ps

package cdts_pkg;

    localparam int DEF_TASK_SLOTS = 64;

    localparam int KIND_W = 2;
    localparam int SLOT_W = 6;
    localparam int PRIO_W = 6;
    localparam int CNT_W  = 7;
    localparam int TASK_W = 6;

    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SCHED = 2'd2;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [CNT_W-1:0]  cnt;
    } entry_t;

endpackage

// ===== rtl/core/counter_decay_task_scheduler_unit.sv =====
// counter decay task scheduler: task slot table, tick handling and iterative scan sequencer
`timescale 1ns / 1ps

// One item at a time: busy rises the cycle after start is taken and falls after the result
// beat, which appears for exactly one cycle with done high and cannot be held off. A slot
// write or kind 3 passes through the report read state to the result, a tick first through
// the tick state. Scheduling walks the slot table through the single read port of the
// priority/counter memory, one slot per cycle, and when every runnable counter is zero a
// recompute pass and a second scan follow; a tick that schedules goes from the tick state
// into the scan. The next item may start the cycle after done.
module counter_decay_task_scheduler_unit #(
    parameter int TASK_SLOTS = cdts_pkg::DEF_TASK_SLOTS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [cdts_pkg::KIND_W-1:0] kind,
    input  logic                        user_mode,
    input  logic [cdts_pkg::SLOT_W-1:0] slot,
    input  logic                        present,
    input  logic                        runnable,
    input  logic [cdts_pkg::PRIO_W-1:0] priority_req,
    input  logic [cdts_pkg::CNT_W-1:0]  slice,
    output logic                        done,
    output logic [cdts_pkg::TASK_W-1:0] next_task,
    output logic                        switched,
    output logic [cdts_pkg::CNT_W-1:0]  current_slice
);

    import cdts_pkg::*;

    localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int EXT_W = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TASK_SLOTS - 1);
    localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_TICK      = 4'd1;
    localparam logic [3:0] S_SCAN      = 4'd2;
    localparam logic [3:0] S_SCAN_TAIL = 4'd3;
    localparam logic [3:0] S_SCAN_DONE = 4'd4;
    localparam logic [3:0] S_RECALC    = 4'd5;
    localparam logic [3:0] S_RECALC_TL = 4'd6;
    localparam logic [3:0] S_REPORT_RD = 4'd7;
    localparam logic [3:0] S_REPORT    = 4'd8;

    logic [3:0]            state_reg, state_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      pidx_reg, pidx_next;
    logic                  pend_reg, pend_next;
    logic                  found_reg, found_next;
    logic [CNT_W-1:0]      top_reg, top_next;
    logic [IDX_W-1:0]      pick_reg, pick_next;
    logic                  recalc_reg, recalc_next;
    logic [IDX_W-1:0]      cur_reg, cur_next;
    logic                  switched_reg, switched_next;
    logic                  user_reg, user_next;
    logic [TASK_SLOTS-1:0] present_reg, present_next;
    logic [TASK_SLOTS-1:0] runnable_reg, runnable_next;
    logic [TASK_SLOTS-1:0] valid_reg, valid_next;

    entry_t                slot_mem_reg [TASK_SLOTS];
    entry_t                rd_data_reg;
    logic                  rd_valid_reg;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_wa;
    entry_t                mem_wd;
    logic [IDX_W-1:0]      mem_ra;
    entry_t                rd_entry;

    logic [EXT_W-1:0]      slot_ext;
    logic [IDX_W-1:0]      wr_idx;
    logic                  wr_in_range;
    logic [EXT_W-1:0]      cur_ext;
    logic                  eligible;

    assign slot_ext    = EXT_W'(slot);
    assign wr_idx      = slot_ext[IDX_W-1:0];
    assign wr_in_range = slot_ext < EXT_W'(TASK_SLOTS);
    assign cur_ext     = EXT_W'(cur_reg);
    assign rd_entry    = rd_valid_reg ? rd_data_reg : '0;
    assign eligible    = present_reg[pidx_reg] & runnable_reg[pidx_reg];

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        pidx_next     = pidx_reg;
        pend_next     = 1'b0;
        found_next    = found_reg;
        top_next      = top_reg;
        pick_next     = pick_reg;
        recalc_next   = recalc_reg;
        cur_next      = cur_reg;
        switched_next = switched_reg;
        user_next     = user_reg;
        present_next  = present_reg;
        runnable_next = runnable_reg;
        mem_we        = 1'b0;
        mem_wa        = cur_reg;
        mem_wd        = '0;
        mem_ra        = cur_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    switched_next = 1'b0;
                    user_next     = user_mode;
                    case (kind)
                        KIND_TICK:
                        begin
                            state_next = S_TICK;
                        end
                        KIND_WRITE:
                        begin
                            if (wr_in_range)
                            begin
                                mem_we                = 1'b1;
                                mem_wa                = wr_idx;
                                mem_wd.prio           = priority_req;
                                mem_wd.cnt            = slice;
                                present_next[wr_idx]  = present;
                                runnable_next[wr_idx] = runnable;
                            end
                            state_next = S_REPORT_RD;
                        end
                        KIND_SCHED:
                        begin
                            switched_next = 1'b1;
                            idx_next      = LAST_IDX;
                            found_next    = 1'b0;
                            top_next      = '0;
                            pick_next     = '0;
                            recalc_next   = 1'b0;
                            state_next    = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_REPORT_RD;
                        end
                    endcase
                end
            end
            S_TICK:
            begin
                mem_we      = 1'b1;
                mem_wa      = cur_reg;
                mem_wd.prio = rd_entry.prio;
                mem_wd.cnt  = (rd_entry.cnt > CNT_W'(1)) ? rd_entry.cnt - CNT_W'(1) : '0;
                if ((rd_entry.cnt <= CNT_W'(1)) && user_reg)
                begin
                    switched_next = 1'b1;
                    idx_next      = LAST_IDX;
                    found_next    = 1'b0;
                    top_next      = '0;
                    pick_next     = '0;
                    recalc_next   = 1'b0;
                    state_next    = S_SCAN;
                end
                else
                begin
                    state_next = S_REPORT_RD;
                end
            end
            S_SCAN:
            begin
                mem_ra    = idx_reg;
                pend_next = 1'b1;
                pidx_next = idx_reg;
                idx_next  = idx_reg - IDX_W'(1);
                if (idx_reg == FIRST_IDX)
                begin
                    state_next = S_SCAN_TAIL;
                end
            end
            S_SCAN_TAIL:
            begin
                state_next = S_SCAN_DONE;
            end
            S_SCAN_DONE:
            begin
                if (found_reg && (top_reg == '0) && !recalc_reg)
                begin
                    recalc_next = 1'b1;
                    idx_next    = LAST_IDX;
                    state_next  = S_RECALC;
                end
                else
                begin
                    cur_next   = found_reg ? pick_reg : '0;
                    state_next = S_REPORT_RD;
                end
            end
            S_RECALC:
            begin
                mem_ra    = idx_reg;
                pend_next = 1'b1;
                pidx_next = idx_reg;
                idx_next  = idx_reg - IDX_W'(1);
                if (idx_reg == FIRST_IDX)
                begin
                    state_next = S_RECALC_TL;
                end
            end
            S_RECALC_TL:
            begin
                idx_next   = LAST_IDX;
                found_next = 1'b0;
                top_next   = '0;
                pick_next  = '0;
                state_next = S_SCAN;
            end
            S_REPORT_RD:
            begin
                mem_ra     = cur_reg;
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // compare beat of a scan: strict greater keeps the higher index on a tie
        if (pend_reg && ((state_reg == S_SCAN) || (state_reg == S_SCAN_TAIL)))
        begin
            if (eligible && (!found_reg || (rd_entry.cnt > top_reg)))
            begin
                found_next = 1'b1;
                top_next   = rd_entry.cnt;
                pick_next  = pidx_reg;
            end
        end

        // recompute beat: halve and add priority for present slots
        if (pend_reg && ((state_reg == S_RECALC) || (state_reg == S_RECALC_TL)))
        begin
            if (present_reg[pidx_reg])
            begin
                mem_we      = 1'b1;
                mem_wa      = pidx_reg;
                mem_wd.prio = rd_entry.prio;
                mem_wd.cnt  = (rd_entry.cnt >> 1) + CNT_W'(rd_entry.prio);
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (mem_we)
        begin
            valid_next[mem_wa] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            pidx_reg     <= '0;
            pend_reg     <= 1'b0;
            found_reg    <= 1'b0;
            top_reg      <= '0;
            pick_reg     <= '0;
            recalc_reg   <= 1'b0;
            cur_reg      <= '0;
            switched_reg <= 1'b0;
            user_reg     <= 1'b0;
            present_reg  <= '0;
            runnable_reg <= '0;
            valid_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            pidx_reg     <= pidx_next;
            pend_reg     <= pend_next;
            found_reg    <= found_next;
            top_reg      <= top_next;
            pick_reg     <= pick_next;
            recalc_reg   <= recalc_next;
            cur_reg      <= cur_next;
            switched_reg <= switched_next;
            user_reg     <= user_next;
            present_reg  <= present_next;
            runnable_reg <= runnable_next;
            valid_reg    <= valid_next;
        end
    end

    // priority and counter store, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem_reg[mem_wa] <= mem_wd;
        end
        rd_data_reg  <= slot_mem_reg[mem_ra];
        rd_valid_reg <= valid_reg[mem_ra];
    end

    assign busy          = state_reg != S_IDLE;
    assign done          = state_reg == S_REPORT;
    assign next_task     = cur_ext[TASK_W-1:0];
    assign switched      = switched_reg;
    assign current_slice = rd_entry.cnt;

endmodule

// ===== rtl/core/cdts_checker.sv =====
// port level checks of the counter decay task scheduler and their binding
`timescale 1ns / 1ps

module cdts_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // a taken beat always occupies the block
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    // the result beat lasts one cycle and frees the block
    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("result beat not followed by idle");

    // results only while an item is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result beat while idle");

    // busy only drops right after a result beat
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("item finished without a result beat");

endmodule

bind counter_decay_task_scheduler_unit cdts_checker u_cdts_checker (.*);
